>>> rtl/core/assert_macros.svh
// Assertion macros used by the checker module of the scanner.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled at the rising clock edge, off during reset.
`define ASC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("Scanner assertion failed.");

// Next-cycle implication, sampled at the rising clock edge, off during reset.
`define ASC_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("Scanner assertion failed.");

`endif

>>> rtl/core/asc_pkg.sv
// Package with the types, codes and constants of the integer scanner.
`timescale 1ns / 1ps
`default_nettype none

package asc_pkg;

  localparam int unsigned ACC_BITS_DEF = 64;
  localparam int unsigned QUEUE_DEPTH = 2;

  typedef enum logic [1:0] {
    MODE_SDEC = 2'd0,
    MODE_UDEC = 2'd1,
    MODE_HEX  = 2'd2,
    MODE_OCT  = 2'd3
  } scan_mode_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_FORMAT = 2'd1,
    ST_RANGE  = 2'd2
  } status_e;

  localparam logic [0:0] REG_SCAN_MODE   = 1'b0;
  localparam logic [0:0] REG_WIDE_RESULT = 1'b1;

  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_7     = 8'h37;
  localparam logic [7:0] CH_8     = 8'h38;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LF    = 8'h66;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UF    = 8'h46;
  localparam logic [7:0] CH_LX    = 8'h78;
  localparam logic [7:0] CH_UX    = 8'h58;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_MINUS = 8'h2d;

  localparam logic [63:0] LIM_U_NARROW   = 64'h0000_0000_ffff_ffff;
  localparam logic [63:0] LIM_S_NARROW   = 64'h0000_0000_7fff_ffff;
  localparam logic [63:0] LIM_NEG_NARROW = 64'h0000_0000_8000_0000;

  typedef struct packed {
    logic [7:0] char_code;
    logic       end_of_stream;
  } in_item_t;

  typedef struct packed {
    logic [63:0] value;
    logic [1:0]  status;
    logic [7:0]  stop_char;
    logic        stop_char_returned;
    logic        stopped_at_end;
  } out_item_t;

  typedef struct packed {
    logic       eos;
    logic [7:0] ch;
    logic       is_minus;
    logic       is_plus;
    logic       is_zero;
    logic       is_x;
    logic       dec_ok;
    logic       oct_ok;
    logic       hex_ok;
    logic [3:0] dval;
  } cls_item_t;

  typedef struct packed {
    logic [1:0] scan_mode;
    logic       wide_result;
  } cfg_t;

endpackage

`default_nettype wire

>>> rtl/core/ascii_integer_scanner.sv
// Top level of the ASCII integer scanner.
//
// Characters enter through a queue-style port: an item transfers at a rising edge
// with push high and full low. Each item holds one character code or an
// end-of-stream mark. Results leave through a second queue-style port: the oldest
// result is on res_o while empty is low and transfers at an edge with pop high.
// One result is produced per number token, on the character that ends it.
// The scanner takes one character per cycle unless the result queue is full. A
// result follows the character that ends the token: that character is written into
// the character queue, is scanned as it leaves, and its result enters the result
// queue at the same edge; the earliest pop is at the following edge. The
// accumulator update for a digit is one shift-and-add per cycle while the scanner
// is not held. Both queues hold two entries, so a stalled receiver fills the result
// queue, then holds the scanner, then raises full. Configuration writes (cfg_we_i,
// cfg_idx_i, cfg_wdata_i) are registered; the user must make them only while the
// block is idle, which is not enforced. Reset empties both queues, returns the
// scanner to idle, selects signed decimal mode and the wide result range.
`timescale 1ns / 1ps
`default_nettype none

module ascii_integer_scanner
  import asc_pkg::*;
#(
  parameter int unsigned ACC_BITS = ACC_BITS_DEF,
  parameter int unsigned DEPTH    = QUEUE_DEPTH
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       push,
  output logic            full,
  input  wire in_item_t   item_i,
  output logic            empty,
  input  wire logic       pop,
  output out_item_t       res_o,
  input  wire logic       cfg_we_i,
  input  wire logic [0:0] cfg_idx_i,
  input  wire logic [1:0] cfg_wdata_i
);

  cfg_t      cfg_q, cfg_d;
  cls_item_t cls;
  logic      cls_empty, cls_pop;
  logic      res_full, res_push;
  out_item_t res_new;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_SCAN_MODE:   cfg_d.scan_mode = cfg_wdata_i;
        REG_WIDE_RESULT: cfg_d.wide_result = cfg_wdata_i[0];
        default:         cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.scan_mode   <= MODE_SDEC;
      cfg_q.wide_result <= 1'b1;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  asc_front #(
    .DEPTH (DEPTH)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .full_o      (full),
    .item_i      (item_i),
    .cls_o       (cls),
    .cls_empty_o (cls_empty),
    .cls_pop_i   (cls_pop)
  );

  asc_back #(
    .ACC_BITS (ACC_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .cls_valid_i (!cls_empty),
    .cls_i       (cls),
    .cls_pop_o   (cls_pop),
    .res_full_i  (res_full),
    .res_push_o  (res_push),
    .res_o       (res_new)
  );

  asc_fifo #(
    .WIDTH ($bits(out_item_t)),
    .DEPTH (DEPTH)
  ) u_res_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .wdata_i (res_new),
    .full_o  (res_full),
    .pop_i   (pop),
    .rdata_o (res_o),
    .empty_o (empty)
  );

endmodule

`default_nettype wire

>>> rtl/core/asc_fifo.sv
// Small register queue with full and empty flags decoded from a registered count.
`timescale 1ns / 1ps
`default_nettype none

module asc_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic [WIDTH-1:0]      rdata_o,
  output logic                  empty_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [AW-1:0]    wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_push) begin
      wptr_d = (wptr_q == AW'(DEPTH - 1)) ? '0 : wptr_q + AW'(1);
    end
    if (do_pop) begin
      rptr_d = (rptr_q == AW'(DEPTH - 1)) ? '0 : rptr_q + AW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/asc_front.sv
// Front end: takes characters, classifies them and queues them for the scanner.
`timescale 1ns / 1ps
`default_nettype none

module asc_front
  import asc_pkg::*;
#(
  parameter int unsigned DEPTH = QUEUE_DEPTH
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      push_i,
  output logic           full_o,
  input  wire in_item_t  item_i,
  output cls_item_t      cls_o,
  output logic           cls_empty_o,
  input  wire logic      cls_pop_i
);

  cls_item_t  cls_in;
  logic [7:0] c;
  logic       is_dec, is_lhex, is_uhex;

  assign c       = item_i.char_code;
  assign is_dec  = (c >= CH_0) && (c <= CH_9);
  assign is_lhex = (c >= CH_LA) && (c <= CH_LF);
  assign is_uhex = (c >= CH_UA) && (c <= CH_UF);

  always_comb begin
    cls_in.eos      = item_i.end_of_stream;
    cls_in.ch       = c;
    cls_in.is_minus = (c == CH_MINUS);
    cls_in.is_plus  = (c == CH_PLUS);
    cls_in.is_zero  = (c == CH_0);
    cls_in.is_x     = (c == CH_LX) || (c == CH_UX);
    cls_in.dec_ok   = is_dec;
    cls_in.oct_ok   = (c >= CH_0) && (c <= CH_7) && (c < CH_8);
    cls_in.hex_ok   = is_dec || is_lhex || is_uhex;
    if (is_lhex) begin
      cls_in.dval = 4'(c - CH_LA + 8'd10);
    end else if (is_uhex) begin
      cls_in.dval = 4'(c - CH_UA + 8'd10);
    end else begin
      cls_in.dval = 4'(c - CH_0);
    end
  end

  asc_fifo #(
    .WIDTH ($bits(cls_item_t)),
    .DEPTH (DEPTH)
  ) u_cls_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push_i),
    .wdata_i (cls_in),
    .full_o  (full_o),
    .pop_i   (cls_pop_i),
    .rdata_o (cls_o),
    .empty_o (cls_empty_o)
  );

endmodule

`default_nettype wire

>>> rtl/core/asc_back.sv
// Back end: token state machine, accumulator and result formation.
`timescale 1ns / 1ps
`default_nettype none

module asc_back
  import asc_pkg::*;
#(
  parameter int unsigned ACC_BITS = ACC_BITS_DEF
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire cfg_t      cfg_i,
  input  wire logic      cls_valid_i,
  input  wire cls_item_t cls_i,
  output logic           cls_pop_o,
  input  wire logic      res_full_i,
  output logic           res_push_o,
  output out_item_t      res_o
);

  localparam int unsigned AW = (ACC_BITS < 32) ? 32 : ((ACC_BITS > 64) ? 64 : ACC_BITS);
  localparam logic [64:0] ONE65 = 65'd1;
  localparam logic [63:0] LIM_U_WIDE   = 64'((ONE65 << AW) - ONE65);
  localparam logic [63:0] LIM_S_WIDE   = 64'((ONE65 << (AW - 1)) - ONE65);
  localparam logic [63:0] LIM_NEG_WIDE = 64'(ONE65 << (AW - 1));

  localparam logic [2:0] PH_IDLE  = 3'd0;
  localparam logic [2:0] PH_SWAIT = 3'd1;
  localparam logic [2:0] PH_UWAIT = 3'd2;
  localparam logic [2:0] PH_SDIG  = 3'd3;
  localparam logic [2:0] PH_UDIG  = 3'd4;
  localparam logic [2:0] PH_HEXZ  = 3'd5;
  localparam logic [2:0] PH_HEXD  = 3'd6;
  localparam logic [2:0] PH_OCTD  = 3'd7;

  localparam logic [1:0] BASE_DEC = 2'd0;
  localparam logic [1:0] BASE_HEX = 2'd1;
  localparam logic [1:0] BASE_OCT = 2'd2;

  logic [2:0]    phase_q, phase_d;
  logic [AW-1:0] acc_q, acc_d;
  logic          neg_q, neg_d;
  logic          ovf_q, ovf_d;

  logic          go, do_acc, fmt, fin, fin_signed;
  logic [1:0]    base;
  logic [AW+3:0] ext, prod, sum;
  logic [63:0]   mag, lim, mag_sat;
  logic          sat, neg_out;

  assign go        = cls_valid_i && !res_full_i;
  assign cls_pop_o = go;

  assign ext = {4'b0, acc_q};
  always_comb begin
    case (base)
      BASE_HEX: prod = ext << 4;
      BASE_OCT: prod = ext << 3;
      default:  prod = (ext << 3) + (ext << 1);
    endcase
    sum = prod + (AW + 4)'(cls_i.dval);
  end

  assign mag     = 64'(acc_q);
  assign neg_out = fin_signed && neg_q;
  always_comb begin
    if (neg_out) begin
      lim = cfg_i.wide_result ? LIM_NEG_WIDE : LIM_NEG_NARROW;
    end else if (fin_signed) begin
      lim = cfg_i.wide_result ? LIM_S_WIDE : LIM_S_NARROW;
    end else begin
      lim = cfg_i.wide_result ? LIM_U_WIDE : LIM_U_NARROW;
    end
    sat     = ovf_q || (mag > lim);
    mag_sat = sat ? lim : mag;
  end

  always_comb begin
    phase_d    = phase_q;
    acc_d      = acc_q;
    neg_d      = neg_q;
    ovf_d      = ovf_q;
    do_acc     = 1'b0;
    base       = BASE_DEC;
    fmt        = 1'b0;
    fin        = 1'b0;
    fin_signed = 1'b0;
    if (go) begin
      case (phase_q)
        PH_IDLE: begin
          if (cls_i.eos) begin
            fmt = 1'b1;
          end else begin
            case (cfg_i.scan_mode)
              MODE_SDEC: begin
                if (cls_i.is_minus) begin
                  neg_d   = 1'b1;
                  phase_d = PH_SWAIT;
                end else if (cls_i.is_plus) begin
                  phase_d = PH_SWAIT;
                end else if (cls_i.dec_ok) begin
                  do_acc  = 1'b1;
                  phase_d = PH_SDIG;
                end else begin
                  fmt = 1'b1;
                end
              end
              MODE_UDEC: begin
                if (cls_i.is_plus) begin
                  phase_d = PH_UWAIT;
                end else if (cls_i.dec_ok) begin
                  do_acc  = 1'b1;
                  phase_d = PH_UDIG;
                end else begin
                  fmt = 1'b1;
                end
              end
              MODE_HEX: begin
                if (cls_i.is_zero) begin
                  phase_d = PH_HEXZ;
                end else begin
                  fmt = 1'b1;
                end
              end
              default: begin
                if (cls_i.is_zero) begin
                  phase_d = PH_OCTD;
                end else begin
                  fmt = 1'b1;
                end
              end
            endcase
          end
        end
        PH_SWAIT, PH_UWAIT: begin
          if (cls_i.eos) begin
            fmt = 1'b1;
          end else if (cls_i.is_plus) begin
            phase_d = phase_q;
          end else if (cls_i.dec_ok) begin
            do_acc  = 1'b1;
            phase_d = (phase_q == PH_SWAIT) ? PH_SDIG : PH_UDIG;
          end else begin
            fmt = 1'b1;
          end
        end
        PH_SDIG, PH_UDIG: begin
          if (!cls_i.eos && cls_i.dec_ok) begin
            do_acc = 1'b1;
          end else begin
            fin        = 1'b1;
            fin_signed = (phase_q == PH_SDIG);
          end
        end
        PH_HEXZ: begin
          if (!cls_i.eos && cls_i.is_x) begin
            phase_d = PH_HEXD;
          end else begin
            fin = 1'b1;
          end
        end
        PH_HEXD: begin
          base = BASE_HEX;
          if (!cls_i.eos && cls_i.hex_ok) begin
            do_acc = 1'b1;
          end else begin
            fin = 1'b1;
          end
        end
        default: begin
          base = BASE_OCT;
          if (!cls_i.eos && cls_i.oct_ok) begin
            do_acc = 1'b1;
          end else begin
            fin = 1'b1;
          end
        end
      endcase
    end

    if (do_acc && !ovf_q) begin
      if (|sum[AW+3:AW]) begin
        ovf_d = 1'b1;
        acc_d = '1;
      end else begin
        acc_d = sum[AW-1:0];
      end
    end

    if (fmt || fin) begin
      phase_d = PH_IDLE;
      acc_d   = '0;
      neg_d   = 1'b0;
      ovf_d   = 1'b0;
    end
  end

  assign res_push_o = fmt || fin;

  always_comb begin
    res_o.stop_char          = cls_i.eos ? 8'd0 : cls_i.ch;
    res_o.stop_char_returned = !cls_i.eos;
    res_o.stopped_at_end     = cls_i.eos;
    if (fmt) begin
      res_o.value  = '0;
      res_o.status = ST_FORMAT;
    end else begin
      res_o.value  = neg_out ? (64'd0 - mag_sat) : mag_sat;
      res_o.status = sat ? ST_RANGE : ST_OK;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      acc_q   <= '0;
      neg_q   <= 1'b0;
      ovf_q   <= 1'b0;
    end else begin
      phase_q <= phase_d;
      acc_q   <= acc_d;
      neg_q   <= neg_d;
      ovf_q   <= ovf_d;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/asc_checker.sv
// Port-level checker for the scanner and its bind to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module asc_checker
  import asc_pkg::*;
(
  input wire logic      clk_i,
  input wire logic      rst_ni,
  input wire logic      empty,
  input wire logic      pop,
  input wire out_item_t res_o
);

  logic status_known;

  assign status_known = (res_o.status == ST_OK) || (res_o.status == ST_FORMAT) ||
                        (res_o.status == ST_RANGE);

  `ASC_ASSERT_IMP(a_status_code, !empty, status_known)
  `ASC_ASSERT_IMP(a_stop_kind, !empty, res_o.stopped_at_end != res_o.stop_char_returned)
  `ASC_ASSERT_IMP(a_end_no_char, !empty && res_o.stopped_at_end, res_o.stop_char == 8'd0)
  `ASC_ASSERT_IMP(a_format_zero, !empty && (res_o.status == ST_FORMAT), res_o.value == 64'd0)
  `ASC_ASSERT_NXT(a_stall_hold, !empty && !pop, !empty && $stable(res_o))

endmodule

bind ascii_integer_scanner asc_checker u_asc_checker (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .empty  (empty),
  .pop    (pop),
  .res_o  (res_o)
);

`default_nettype wire

>>> sim/scan_checker.sv
// Checker that predicts the integer scanner's results and compares them with the block's output.
`timescale 1ns / 1ps

module scan_checker
  import asc_pkg::*;
#(
  parameter int unsigned ACC_BITS = ACC_BITS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  logic       full_i,
  input  in_item_t   item_i,
  input  logic       empty_i,
  input  logic       pop_i,
  input  out_item_t  res_i,
  input  logic       cfg_we_i,
  input  logic [0:0] cfg_idx_i,
  input  logic [1:0] cfg_wdata_i,
  output int         mismatch_count_o,
  output int         results_pending_o
);

  localparam int unsigned ACC_W = (ACC_BITS < 32) ? 32 : ((ACC_BITS > 64) ? 64 : ACC_BITS);

  typedef enum logic [2:0] {
    SCAN_IDLE,
    SCAN_SIGNED_LEAD,
    SCAN_UNSIGNED_LEAD,
    SCAN_SIGNED_DIGITS,
    SCAN_UNSIGNED_DIGITS,
    SCAN_HEX_ZERO,
    SCAN_HEX_DIGITS,
    SCAN_OCT_DIGITS
  } scan_phase_e;

  scan_phase_e phase;
  logic [63:0] acc;
  logic        negative;
  logic        saturated;
  scan_mode_e  mode;
  logic        wide;
  out_item_t   results_due[$];
  out_item_t   want;
  int          mismatches = 0;
  int          results_seen = 0;

  assign mismatch_count_o = mismatches;

  function automatic logic [63:0] ones(int unsigned w);
    return (w >= 64) ? '1 : ((64'd1 << w) - 64'd1);
  endfunction

  function automatic int digit_value(logic [7:0] c, int unsigned base);
    if (c >= CH_0 && c <= CH_9) begin
      return (32'(c - CH_0) < base) ? int'(c - CH_0) : -1;
    end
    if (base == 16 && c >= CH_LA && c <= CH_LF) return int'(c - CH_LA) + 10;
    if (base == 16 && c >= CH_UA && c <= CH_UF) return int'(c - CH_UA) + 10;
    return -1;
  endfunction

  task automatic report_mismatch(input string field, input logic [63:0] got,
                                 input logic [63:0] wanted);
    mismatches++;
    $display("%0t ns: result %0d: %s is %0h, expected %0h", $time, results_seen, field,
             got, wanted);
  endtask

  task automatic clear_scan();
    phase = SCAN_IDLE;
    acc = '0;
    negative = 1'b0;
    saturated = 1'b0;
  endtask

  task automatic add_digit(input int d, input int unsigned base);
    logic [63:0] lim;
    lim = ones(ACC_W);
    if (!saturated) begin
      if (acc > (lim - 64'(d)) / 64'(base)) begin
        saturated = 1'b1;
        acc = lim;
      end else begin
        acc = acc * 64'(base) + 64'(d);
      end
    end
  endtask

  task automatic post_result(input logic [63:0] val, input status_e st, input in_item_t it);
    out_item_t r;
    r.value = val;
    r.status = st;
    r.stop_char = it.end_of_stream ? 8'h00 : it.char_code;
    r.stop_char_returned = !it.end_of_stream;
    r.stopped_at_end = it.end_of_stream;
    results_due.push_back(r);
    clear_scan();
  endtask

  task automatic close_token(input logic is_signed, input in_item_t it);
    int unsigned w;
    logic [63:0] mag;
    logic [63:0] lim;
    status_e st;
    w = wide ? ACC_W : 32;
    mag = acc;
    st = ST_OK;
    if (is_signed && negative) begin
      lim = 64'd1 << (w - 1);
      if (saturated || mag > lim) begin
        st = ST_RANGE;
        mag = lim;
      end
      post_result(64'd0 - mag, st, it);
    end else begin
      lim = is_signed ? ones(w - 1) : ones(w);
      if (saturated || mag > lim) begin
        st = ST_RANGE;
        mag = lim;
      end
      post_result(mag, st, it);
    end
  endtask

  // An end-of-stream item is scanned as the code zero, which is never a digit, a sign or x,
  // so it ends the token wherever it falls.
  task automatic scan_char(input in_item_t it);
    logic [7:0] c;
    int d;
    c = it.end_of_stream ? 8'h00 : it.char_code;
    case (phase)
      SCAN_IDLE: begin
        if (mode == MODE_SDEC || mode == MODE_UDEC) begin
          d = digit_value(c, 10);
          if (mode == MODE_SDEC && c == CH_MINUS) begin
            negative = 1'b1;
            phase = SCAN_SIGNED_LEAD;
          end else if (c == CH_PLUS) begin
            phase = (mode == MODE_SDEC) ? SCAN_SIGNED_LEAD : SCAN_UNSIGNED_LEAD;
          end else if (d < 0) begin
            post_result(64'd0, ST_FORMAT, it);
          end else begin
            add_digit(d, 10);
            phase = (mode == MODE_SDEC) ? SCAN_SIGNED_DIGITS : SCAN_UNSIGNED_DIGITS;
          end
        end else if (c != CH_0) begin
          post_result(64'd0, ST_FORMAT, it);
        end else begin
          phase = (mode == MODE_HEX) ? SCAN_HEX_ZERO : SCAN_OCT_DIGITS;
        end
      end
      SCAN_SIGNED_LEAD, SCAN_UNSIGNED_LEAD: begin
        d = digit_value(c, 10);
        if (c == CH_PLUS && !it.end_of_stream) begin
          phase = phase;
        end else if (d < 0) begin
          post_result(64'd0, ST_FORMAT, it);
        end else begin
          add_digit(d, 10);
          phase = (phase == SCAN_SIGNED_LEAD) ? SCAN_SIGNED_DIGITS : SCAN_UNSIGNED_DIGITS;
        end
      end
      SCAN_SIGNED_DIGITS, SCAN_UNSIGNED_DIGITS: begin
        d = digit_value(c, 10);
        if (d < 0) close_token(phase == SCAN_SIGNED_DIGITS, it);
        else add_digit(d, 10);
      end
      SCAN_HEX_ZERO: begin
        if (c == CH_LX || c == CH_UX) phase = SCAN_HEX_DIGITS;
        else close_token(1'b0, it);
      end
      SCAN_HEX_DIGITS: begin
        d = digit_value(c, 16);
        if (d < 0) close_token(1'b0, it);
        else add_digit(d, 16);
      end
      default: begin
        d = digit_value(c, 8);
        if (d < 0) close_token(1'b0, it);
        else add_digit(d, 8);
      end
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_scan();
      mode = MODE_SDEC;
      wide = 1'b1;
      results_due.delete();
      results_pending_o <= 0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == REG_SCAN_MODE) mode = scan_mode_e'(cfg_wdata_i);
        else wide = cfg_wdata_i[0];
      end
      if (pop_i && !empty_i) begin
        if (results_due.size() == 0) begin
          report_mismatch("unexpected result, value", res_i.value, '0);
        end else begin
          want = results_due.pop_front();
          if (res_i.value !== want.value) report_mismatch("value", res_i.value, want.value);
          if (res_i.status !== want.status) begin
            report_mismatch("status", 64'(res_i.status), 64'(want.status));
          end
          if (res_i.stop_char !== want.stop_char) begin
            report_mismatch("stop_char", 64'(res_i.stop_char), 64'(want.stop_char));
          end
          if (res_i.stop_char_returned !== want.stop_char_returned) begin
            report_mismatch("stop_char_returned", 64'(res_i.stop_char_returned),
                            64'(want.stop_char_returned));
          end
          if (res_i.stopped_at_end !== want.stopped_at_end) begin
            report_mismatch("stopped_at_end", 64'(res_i.stopped_at_end),
                            64'(want.stopped_at_end));
          end
        end
        results_seen++;
      end
      if (push_i && !full_i) scan_char(item_i);
      results_pending_o <= results_due.size();
    end
  end

endmodule

>>> sim/ascii_integer_scanner_tb.sv
// Testbench top of the integer scanner: clock, reset, character stimulus and the verdict.
`timescale 1ns / 1ps

module ascii_integer_scanner_tb;
  import asc_pkg::*;

  logic       clk_i = 1'b0;
  logic       rst_ni;
  logic       push;
  logic       full;
  in_item_t   item;
  logic       empty;
  logic       pop = 1'b0;
  out_item_t  res;
  logic       cfg_we;
  logic [0:0] cfg_idx;
  logic [1:0] cfg_wdata;

  int         mismatch_count;
  int         results_pending;
  int         gap_pct = 0;
  int         stall_pct = 0;
  int         stall_left = 0;
  int         items_sent = 0;
  scan_mode_e cur_mode = MODE_SDEC;
  in_item_t   token[$];

  always #4 clk_i = ~clk_i;

  ascii_integer_scanner u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .item_i      (item),
    .empty       (empty),
    .pop         (pop),
    .res_o       (res),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  scan_checker u_checker (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .push_i            (push),
    .full_i            (full),
    .item_i            (item),
    .empty_i           (empty),
    .pop_i             (pop),
    .res_i             (res),
    .cfg_we_i          (cfg_we),
    .cfg_idx_i         (cfg_idx),
    .cfg_wdata_i       (cfg_wdata),
    .mismatch_count_o  (mismatch_count),
    .results_pending_o (results_pending)
  );

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      pop <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      pop <= 1'b0;
    end else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
      stall_left <= $urandom_range(0, 3);
      pop <= 1'b0;
    end else begin
      pop <= 1'b1;
    end
  end

  function automatic in_item_t char_item(logic [7:0] c);
    return '{char_code: c, end_of_stream: 1'b0};
  endfunction

  function automatic in_item_t eos_item();
    return '{char_code: 8'($urandom_range(0, 255)), end_of_stream: 1'b1};
  endfunction

  function automatic bit is_digit_of(logic [7:0] c, int base);
    if (c >= CH_0 && c <= CH_9) return int'(c - CH_0) < base;
    if (base == 16) return (c >= CH_LA && c <= CH_LF) || (c >= CH_UA && c <= CH_UF);
    return 1'b0;
  endfunction

  function automatic logic [7:0] digit_char(int dv);
    if (dv < 10) return CH_0 + 8'(dv);
    return ($urandom_range(0, 1) ? CH_UA : CH_LA) + 8'(dv - 10);
  endfunction

  function automatic logic [63:0] pick_magnitude();
    logic [63:0] lim_val;
    case ($urandom_range(0, 4))
      0: return 64'($urandom_range(0, 999));
      1: return {32'd0, $urandom};
      2: return {$urandom, $urandom};
      default: begin
        case ($urandom_range(0, 4))
          0: lim_val = LIM_S_NARROW;
          1: lim_val = LIM_NEG_NARROW;
          2: lim_val = LIM_U_NARROW;
          3: lim_val = 64'h7fff_ffff_ffff_ffff;
          default: lim_val = 64'hffff_ffff_ffff_ffff;
        endcase
        return lim_val + 64'($urandom_range(0, 4)) - 64'd2;
      end
    endcase
  endfunction

  task automatic send_item(input in_item_t it);
    if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    push <= 1'b1;
    item <= it;
    do @(posedge clk_i); while (full);
    items_sent++;
  endtask

  task automatic send_char(input logic [7:0] c);
    send_item(char_item(c));
  endtask

  task automatic send_eos();
    send_item(eos_item());
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i]);
  endtask

  task automatic write_reg(input logic [0:0] idx, input logic [1:0] data);
    push <= 1'b0;
    @(posedge clk_i);
    while (results_pending != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= data;
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  task automatic append_number(input logic [63:0] v, input int base);
    logic [7:0] digs[$];
    if (v == 0) digs.push_back(CH_0);
    while (v != 0) begin
      digs.push_front(digit_char(int'(v % 64'(base))));
      v = v / 64'(base);
    end
    foreach (digs[i]) token.push_back(char_item(digs[i]));
  endtask

  task automatic build_token();
    int base;
    int r;
    logic [7:0] c;
    token.delete();
    r = $urandom_range(0, 99);
    if (r < 18) begin
      repeat ($urandom_range(1, 8)) begin
        if ($urandom_range(0, 9) == 0) token.push_back(eos_item());
        else token.push_back(char_item(8'($urandom_range(0, 255))));
      end
      return;
    end
    base = (cur_mode == MODE_HEX) ? 16 : ((cur_mode == MODE_OCT) ? 8 : 10);
    case (cur_mode)
      MODE_SDEC: begin
        case ($urandom_range(0, 2))
          1: token.push_back(char_item(CH_MINUS));
          2: token.push_back(char_item(CH_PLUS));
          default: ;
        endcase
        if ($urandom_range(0, 3) == 0) begin
          repeat ($urandom_range(1, 3)) token.push_back(char_item(CH_PLUS));
        end
      end
      MODE_UDEC: begin
        if ($urandom_range(0, 2) == 0) begin
          repeat ($urandom_range(1, 3)) token.push_back(char_item(CH_PLUS));
        end
      end
      MODE_HEX: begin
        token.push_back(char_item(CH_0));
        if (r < 30) begin
          do c = 8'($urandom_range(0, 255)); while (c == CH_LX || c == CH_UX);
          token.push_back(char_item(c));
          return;
        end
        token.push_back(char_item($urandom_range(0, 1) ? CH_UX : CH_LX));
      end
      default: token.push_back(char_item(CH_0));
    endcase
    if ($urandom_range(0, 9) != 0) begin
      if ($urandom_range(0, 7) == 0) begin
        repeat ($urandom_range(1, 2)) token.push_back(char_item(CH_0));
      end
      append_number(pick_magnitude(), base);
      if ($urandom_range(0, 7) == 0) begin
        repeat ($urandom_range(1, 3)) begin
          token.push_back(char_item(digit_char($urandom_range(0, base - 1))));
        end
      end
    end
    if ($urandom_range(0, 3) == 0) begin
      token.push_back(eos_item());
    end else begin
      do c = 8'($urandom_range(0, 255)); while (is_digit_of(c, base));
      token.push_back(char_item(c));
    end
  endtask

  task automatic send_token();
    foreach (token[i]) send_item(token[i]);
  endtask

  function automatic int pick_pct();
    case ($urandom_range(0, 2))
      0: return 0;
      1: return 15;
      default: return 40;
    endcase
  endfunction

  initial begin
    logic [1:0] m;
    push = 1'b0;
    item = '0;
    cfg_we = 1'b0;
    cfg_idx = '0;
    cfg_wdata = '0;
    rst_ni = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    gap_pct = 15;
    stall_pct = 15;
    send_eos();
    send_text("-0,");
    send_text("+-");
    send_text("++7");
    send_eos();
    write_reg(REG_WIDE_RESULT, 2'b10);
    write_reg(REG_SCAN_MODE, MODE_UDEC);
    cur_mode = MODE_UDEC;
    send_text("+5");
    send_char(8'h00);
    write_reg(REG_SCAN_MODE, MODE_HEX);
    cur_mode = MODE_HEX;
    send_char(CH_0);
    send_char(8'hff);
    send_text("0x;");
    send_text("0XfF");
    send_eos();
    // The token started in hex mode has to finish in hex mode.
    send_text("0x");
    write_reg(REG_SCAN_MODE, MODE_SDEC);
    cur_mode = MODE_SDEC;
    send_text("a ");
    write_reg(REG_SCAN_MODE, MODE_OCT);
    cur_mode = MODE_OCT;
    send_text("078");
    send_text("1");

    items_sent = 0;
    while (items_sent < 1600) begin
      if (items_sent > 1400) begin
        gap_pct = 0;
        stall_pct = 0;
      end else begin
        gap_pct = pick_pct();
        stall_pct = pick_pct();
      end
      m = 2'($urandom_range(0, 3));
      write_reg(REG_SCAN_MODE, m);
      cur_mode = scan_mode_e'(m);
      if ($urandom_range(0, 2) != 0) write_reg(REG_WIDE_RESULT, 2'($urandom_range(0, 3)));
      repeat ($urandom_range(4, 16)) begin
        build_token();
        send_token();
      end
      send_eos();
    end

    push <= 1'b0;
    @(posedge clk_i);
    while (results_pending != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (mismatch_count == 0 && results_pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
